/* rtl/triangle_polytope_clip_test_assert.svh */
`ifndef TRIANGLE_POLYTOPE_CLIP_TEST_ASSERT_SVH
`define TRIANGLE_POLYTOPE_CLIP_TEST_ASSERT_SVH
// Assertion helpers for the clip test block.
`define TPC_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define TPC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

/* rtl/tpc_pkg.sv */
`timescale 1ns / 1ps
package tpc_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned NormW = 16;
  localparam logic REQ_PLANE = 1'b0;
  localparam logic REQ_VERTEX = 1'b1;
  localparam logic [0:0] CFG_ENABLE = 1'b0;
  localparam logic [0:0] CFG_COUNT = 1'b1;

  typedef struct packed {
    logic req_type;
    logic [2:0] plane_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
    logic [1:0] vertex_slot;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
  } in_item_t;

  typedef struct packed {
    logic contained;
    logic [3:0] vertices_left;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    vec_t v0;
    vec_t v1;
    vec_t v2;
  } tri_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_PLANE, ST_RD, ST_DP, ST_DC, ST_DSUM, ST_CHK,
    ST_DIV, ST_CUT, ST_PUSHC, ST_NEXT, ST_END, ST_OUT
  } eng_state_t;
endpackage

/* rtl/tpc_stream_if.sv */
`timescale 1ns / 1ps
interface tpc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tpc_front.sv */
`timescale 1ns / 1ps
module tpc_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tpc_pkg::in_item_t in_data,
  input  logic eng_busy,
  output logic q_valid,
  input  logic q_ready,
  output tpc_pkg::tri_t q_tri,
  output logic pl_we,
  output logic [2:0] pl_idx,
  output logic [79:0] pl_data
);
  import tpc_pkg::*;
  // Two-entry queue of complete triangles.
  vec_t c0_r, c1_r;
  tri_t fifo_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic acc, push, pop, is_plane;

  assign is_plane = (in_data.req_type == REQ_PLANE);
  // A plane load is held back while a triangle is queued or being clipped, so that
  // every triangle sees the planes that were loaded before its last corner.
  assign in_ready = (cnt_r != 2'd2) && !(is_plane && (cnt_r != 2'd0 || eng_busy));
  assign acc = in_valid && in_ready;
  assign push = acc && in_data.req_type == REQ_VERTEX && in_data.vertex_slot == 2'd2;
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_tri = fifo_r[rp_r];
  assign pl_we = acc && is_plane;
  assign pl_idx = in_data.plane_index;
  assign pl_data = {in_data.normal_x, in_data.normal_y, in_data.normal_z,
                    in_data.plane_offset};
  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.req_type == REQ_VERTEX) begin
      if (in_data.vertex_slot == 2'd0)
        c0_r <= {in_data.vert_x, in_data.vert_y, in_data.vert_z};
      if (in_data.vertex_slot == 2'd1)
        c1_r <= {in_data.vert_x, in_data.vert_y, in_data.vert_z};
    end
    if (push)
      fifo_r[wp_r] <= {c0_r, c1_r, in_data.vert_x, in_data.vert_y, in_data.vert_z};
  end
endmodule

/* rtl/tpc_engine.sv */
`timescale 1ns / 1ps
module tpc_engine #(
  parameter int MAX_PLANES = 8,
  parameter int LIST_DEPTH = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  tpc_pkg::tri_t q_tri,
  output logic busy,
  input  logic pl_we,
  input  logic [2:0] pl_idx,
  input  logic [79:0] pl_data,
  input  logic [7:0] enable,
  input  logic [3:0] count,
  output logic out_valid,
  input  logic out_ready,
  output tpc_pkg::out_item_t out_data
);
  import tpc_pkg::*;
  localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int LW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(2 * LIST_DEPTH);

  logic [79:0] planes_r [MAX_PLANES];
  vec_t list_r [2 * LIST_DEPTH];

  eng_state_t st_r, st_nxt;
  logic [5:0] p_r, p_nxt;
  logic [LW-1:0] n_r, n_nxt, m_r, m_nxt, i_r, i_nxt;
  logic src_r, src_nxt;
  logic [79:0] pln_r;
  vec_t vp_r, vc_r, rd_r;
  logic signed [63:0] dp_r, dc_r;
  logic [63:0] sum_r, rem_r;
  logic [16:0] q_r;
  logic [4:0] k_r;
  out_item_t res_r, res_nxt;
  logic [1:0] ax_r;
  logic [1:0] dcnt_r;

  logic [3:0] lim;
  assign lim = (32'(count) > MAX_PLANES) ? 4'(MAX_PLANES) : count;

  always_ff @(posedge clk) begin
    if (pl_we && 32'(pl_idx) < MAX_PLANES) planes_r[PW'(pl_idx)] <= pl_data;
  end

  // Distance unit: one product per cycle, four terms.
  function automatic logic signed [63:0] fl15(input logic signed [63:0] a);
    fl15 = a >>> 15;
  endfunction

  logic signed [63:0] prod;
  logic signed [31:0] comp_v;
  logic signed [15:0] comp_n;
  vec_t dv;
  assign dv = (st_r == ST_DP) ? vp_r : vc_r;
  always_comb begin
    unique case (dcnt_r)
      2'd0: begin comp_v = dv.x; comp_n = pln_r[79:64]; end
      2'd1: begin comp_v = dv.y; comp_n = pln_r[63:48]; end
      2'd2: begin comp_v = dv.z; comp_n = pln_r[47:32]; end
      default: begin comp_v = pln_r[31:0]; comp_n = 16'sh4000; end
    endcase
    prod = 64'(comp_n) * 64'(comp_v);
    if (dcnt_r == 2'd3) prod = prod <<< 1;
  end

  logic signed [63:0] acc64_r;
  logic [AW-1:0] ra;
  logic [LW-1:0] ci;
  assign ci = (i_r + 1'b1 == n_r) ? '0 : i_r + 1'b1;

  // Cut point: one axis per cycle.
  logic signed [31:0] ca, cb;
  logic signed [63:0] cprod;
  logic signed [31:0] cres;
  always_comb begin
    unique case (ax_r)
      2'd0: begin ca = vp_r.x; cb = vc_r.x; end
      2'd1: begin ca = vp_r.y; cb = vc_r.y; end
      default: begin ca = vp_r.z; cb = vc_r.z; end
    endcase
    cprod = (64'(cb) - 64'(ca)) * $signed({47'd0, q_r});
    cres = 32'(64'(ca) + (cprod >>> 16));
  end

  logic pushv, pushc;
  logic [AW-1:0] wa;
  logic [63:0] ap, ac;
  assign ap = dp_r[63] ? 64'(-dp_r) : 64'(dp_r);
  assign ac = dc_r[63] ? 64'(-dc_r) : 64'(dc_r);

  always_comb begin
    st_nxt = st_r; p_nxt = p_r; n_nxt = n_r; m_nxt = m_r; i_nxt = i_r;
    src_nxt = src_r; res_nxt = res_r;
    q_ready = 1'b0; out_valid = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          res_nxt = '{contained: 1'b1, vertices_left: 4'd4};
          p_nxt = '0; n_nxt = LW'(3); src_nxt = 1'b0;
          st_nxt = (enable == 8'd0) ? ST_OUT : ST_PLANE;
        end
      end
      ST_PLANE: begin
        if (p_r >= 6'(lim)) begin
          res_nxt.vertices_left = 4'(n_r + 1'b1);
          st_nxt = ST_OUT;
        end else if (p_r >= 6'd8 || !enable[p_r[2:0]]) begin
          p_nxt = p_r + 1'b1;
        end else begin
          i_nxt = '0; m_nxt = '0; st_nxt = ST_START;
        end
      end
      ST_START: st_nxt = ST_RD;
      ST_RD: st_nxt = ST_DP;
      ST_DP: if (dcnt_r == 2'd3) st_nxt = ST_DC;
      ST_DC: if (dcnt_r == 2'd3) st_nxt = ST_CHK;
      ST_CHK: begin
        if (!dp_r[63] && m_r < LW'(LIST_DEPTH - 1)) m_nxt = m_r + 1'b1;
        if ((dp_r > 0 && dc_r < 0) || (dp_r < 0 && dc_r > 0)) st_nxt = ST_DSUM;
        else st_nxt = ST_NEXT;
      end
      ST_DSUM: st_nxt = ST_DIV;
      ST_DIV: if (k_r == 5'd0) st_nxt = ST_CUT;
      ST_CUT: if (ax_r == 2'd2) st_nxt = ST_PUSHC;
      ST_PUSHC: begin
        if (m_r < LW'(LIST_DEPTH - 1)) m_nxt = m_r + 1'b1;
        st_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (i_r + 1'b1 == n_r) st_nxt = ST_END;
        else begin i_nxt = i_r + 1'b1; st_nxt = ST_RD; end
      end
      ST_END: begin
        if (m_r <= LW'(1)) begin
          res_nxt = '{contained: 1'b0, vertices_left: 4'(m_r)};
          st_nxt = ST_OUT;
        end else begin
          n_nxt = m_r; src_nxt = ~src_r; p_nxt = p_r + 1'b1; st_nxt = ST_PLANE;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
  assign out_data = res_r;
  assign busy = (st_r != ST_IDLE);
  assign pushv = (st_r == ST_CHK) && !dp_r[63] && m_r < LW'(LIST_DEPTH - 1);
  assign pushc = (st_r == ST_PUSHC) && m_r < LW'(LIST_DEPTH - 1);

  always_comb begin
    ra = AW'(src_r ? LIST_DEPTH : 0) + AW'((st_r == ST_RD) ? i_r : ci);
    wa = AW'(src_r ? 0 : LIST_DEPTH) + AW'(m_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; p_r <= '0; n_r <= '0; m_r <= '0; i_r <= '0;
      src_r <= 1'b0; res_r <= '0; dcnt_r <= '0; ax_r <= '0;
      k_r <= '0;
    end else begin
      st_r <= st_nxt; p_r <= p_nxt; n_r <= n_nxt; m_r <= m_nxt; i_r <= i_nxt;
      src_r <= src_nxt; res_r <= res_nxt;
      dcnt_r <= (st_r == ST_DP || st_r == ST_DC) ? dcnt_r + 1'b1 : 2'd0;
      ax_r <= (st_r == ST_CUT) ? ((ax_r == 2'd2) ? 2'd0 : ax_r + 1'b1) : 2'd0;
      if (st_r == ST_DSUM) k_r <= 5'd16;
      else if (st_r == ST_DIV && k_r != 0) k_r <= k_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_valid) begin
      list_r[0] <= q_tri.v0; list_r[1] <= q_tri.v1; list_r[2] <= q_tri.v2;
    end else if (pushv) list_r[wa] <= vp_r;
    else if (pushc) list_r[wa] <= vc_r;
    rd_r <= list_r[ra];
    if (st_r == ST_START) pln_r <= planes_r[p_r[PW-1:0]];
    if (st_r == ST_RD) vp_r <= list_r[ra];
    // The first distance step addresses the far end of the edge.
    if (st_r == ST_DP && dcnt_r == 2'd1) vc_r <= rd_r;
    if (st_r == ST_DP || st_r == ST_DC)
      acc64_r <= (dcnt_r == 2'd0) ? prod : acc64_r + prod;
    if (st_r == ST_DC && dcnt_r == 2'd0) dp_r <= fl15(acc64_r);
    if (st_r == ST_DC && dcnt_r == 2'd3) dc_r <= fl15(acc64_r + prod);
    if (st_r == ST_DSUM) begin
      sum_r <= ap + ac; rem_r <= ap; q_r <= '0;
    end
    if (st_r == ST_DIV && k_r != 0) begin
      if ({rem_r[62:0], 1'b0} >= sum_r) begin
        rem_r <= {rem_r[62:0], 1'b0} - sum_r; q_r <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= {rem_r[62:0], 1'b0}; q_r <= {q_r[15:0], 1'b0};
      end
    end
    if (st_r == ST_CUT) begin
      unique case (ax_r)
        2'd0: vc_r.x <= cres;
        2'd1: vc_r.y <= cres;
        default: vc_r.z <= cres;
      endcase
    end
  end
  // dp is latched at the first step of the second distance pass; the
  // cut overwrites vc, and the next edge reloads both from the list.
endmodule

/* rtl/triangle_polytope_clip_test.sv */
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in      | in  | plane load or triangle corner
// out     | out | contained, vertices_left
// cfg     | in  | plane_enable (0), plane_count (1)
// A corner 0/1 is kept in a register; a corner 2 goes to a two-triangle queue.
// A plane load waits while any triangle is queued or being clipped.
// The engine passes over a disabled plane and works through every edge of an
// enabled one; a cut edge adds a 16-step division and a cut point, one axis per cycle.
// rst_n is synchronous; the engine holds a result until out_ready.
module triangle_polytope_clip_test #(
  parameter int MAX_PLANES = 8,
  parameter int LIST_DEPTH = 12
) (
  input logic clk,
  input logic rst_n,
  tpc_stream_if.sink in_ch,
  tpc_stream_if.source out_ch,
  input logic cfg_we,
  input logic [0:0] cfg_index,
  input logic [7:0] cfg_data
);
  import tpc_pkg::*;
  logic [7:0] en_r;
  logic [3:0] cnt_r;
  logic qv, qr, pw, eb;
  tri_t qt;
  logic [2:0] pi;
  logic [79:0] pd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin en_r <= 8'hFF; cnt_r <= '0; end
    else if (cfg_we) begin
      if (cfg_index == CFG_ENABLE) en_r <= cfg_data;
      if (cfg_index == CFG_COUNT) cnt_r <= cfg_data[3:0];
    end
  end

  tpc_front u_front (.clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .eng_busy(eb), .q_valid(qv), .q_ready(qr), .q_tri(qt),
    .pl_we(pw), .pl_idx(pi), .pl_data(pd));

  tpc_engine #(.MAX_PLANES(MAX_PLANES), .LIST_DEPTH(LIST_DEPTH)) u_eng (
    .clk, .rst_n, .q_valid(qv), .q_ready(qr), .q_tri(qt), .busy(eb), .pl_we(pw),
    .pl_idx(pi), .pl_data(pd), .enable(en_r), .count(cnt_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
endmodule

/* rtl/tpc_checker.sv */
`timescale 1ns / 1ps
`include "triangle_polytope_clip_test_assert.svh"
module tpc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_contained,
  input logic [3:0] out_left
);
  `TPC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `TPC_ASSERT_IMPL(a_fail_small, clk, rst_n, out_valid && !out_contained, out_left <= 4'd1)
  `TPC_ASSERT_IMPL(a_pass_big, clk, rst_n, out_valid && out_contained, out_left >= 4'd3)
endmodule

bind triangle_polytope_clip_test tpc_checker u_chk (.clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_contained(out_ch.data.contained), .out_left(out_ch.data.vertices_left));
